// ----- rtl/cpm_pkg.sv -----
// Shared constants and types for the comparison bit pattern matcher.
package cpm_pkg;

  localparam int SAMPLE_WIDTH     = 32;
  localparam int MAX_PATTERN_BITS = 64;
  localparam int MIN_PATTERN_BITS = 4;
  localparam int COUNT_W          = 32;
  localparam int PATTERN_LENGTH_W = 7;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 64;
  localparam int OUT_TDATA_W      = 2 * COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BITS   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(1);

  // Per-step control shared by every cell of the chain.
  typedef struct packed {
    logic clear;    // end of text: drop the comparison history
    logic advance;  // a new comparison bit enters the chain
  } cell_ctrl_t;

  // One result transaction.
  typedef struct packed {
    logic [COUNT_W-1:0] match_total;
    logic [COUNT_W-1:0] match_start;
    logic               match_found;
  } result_t;

endpackage

// ----- rtl/cpm_cell.sv -----
// One cell of the comparison history chain: holds one comparison bit and flags a pattern mismatch.
module cpm_cell (
  input  logic              clk,
  input  logic              rst,
  input  cpm_pkg::cell_ctrl_t ctrl,
  input  logic              shift_in,
  input  logic              tgt_bit,
  input  logic              mask_bit,
  output logic              hist,
  output logic              miss
);
  import cpm_pkg::*;

  // Compare the bit this cell takes on this step against its aligned pattern bit.
  assign miss = mask_bit & (shift_in ^ tgt_bit);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hist <= 1'b0;
    end else if (ctrl.advance) begin
      hist <= shift_in;
    end
  end

endmodule

// ----- rtl/cpm_out_buf.sv -----
// Output register with a skid stage so the input side keeps flowing while a result waits.
module cpm_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cpm_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  output cpm_pkg::result_t out_data,
  input  logic             out_ready
);
  import cpm_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- rtl/comparison_bit_pattern_matcher_top.sv -----
// Top level of the comparison bit pattern matcher: cell chain, text counters and output buffer.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata = sample, s_tlast = last_sample
//  m_*      | out       | m_tvalid/m_tready  | m_tdata = match_start, match_total;
//           |           |                    | m_tuser = match_found
//  cfg_*    | in        | cfg_wr_en          | cfg_index selects register, cfg_data
//
// One sample is taken per cycle while s_tready is high; each produces exactly one result transaction.
// That result is registered in the output register, or in the skid stage while the output is stalled.
// A chain of MAX_PATTERN_BITS cells holds the comparison history, newest in the
// top cell; each step after the first of a text shifts the row down one cell.
// Each of the top pattern_length cells checks its new bit against its aligned
// pattern bit, so a match needs no mismatch, a valid pattern_length and enough comparisons.
// A skid stage behind the output register lets the input keep flowing for one
// more transaction while m_tready is low; s_tready drops only once that stage
// is full. rst is synchronous and clears all control state; the registers
// return to pattern_bits 0, pattern_length 4.
module comparison_bit_pattern_matcher_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_wr_en,
  input  logic [cpm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [cpm_pkg::CFG_DATA_W-1:0]         cfg_data,
  // sample stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [cpm_pkg::SAMPLE_WIDTH-1:0]       s_tdata,   // [31:0] sample
  input  logic                                   s_tlast,   // last_sample
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [cpm_pkg::OUT_TDATA_W-1:0]        m_tdata,   // [31:0] match_start,
                                                            // [63:32] match_total
  output logic                                   m_tuser    // match_found
);
  import cpm_pkg::*;

  // Configuration registers.
  logic [MAX_PATTERN_BITS-1:0] pattern_bits;
  logic [PATTERN_LENGTH_W-1:0] pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= '0;
      pattern_length <= PATTERN_LENGTH_W'(MIN_PATTERN_BITS);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_BITS:   pattern_bits   <= cfg_data[MAX_PATTERN_BITS-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PATTERN_LENGTH_W-1:0];
      endcase
    end
  end

  // Per-text state.
  logic [SAMPLE_WIDTH-1:0] previous_value;
  logic [COUNT_W-1:0]      samples_seen;
  logic [COUNT_W-1:0]      matches_counted;

  logic       accept;
  logic       has_prev;
  logic       cmp_bit;
  cell_ctrl_t ctrl;

  assign accept   = s_tvalid && s_tready;
  assign has_prev = (samples_seen != '0);
  // Earlier sample strictly greater, signed compare.
  assign cmp_bit  = $signed(previous_value) > $signed(s_tdata);

  assign ctrl.clear   = accept && s_tlast;
  assign ctrl.advance = accept && has_prev;

  // Align the pattern to the top pattern_length cells: pattern bit 0 meets
  // the oldest comparison of the window, the top bit the newest one.
  logic [PATTERN_LENGTH_W-1:0] shamt;
  logic [MAX_PATTERN_BITS-1:0] target;
  logic [MAX_PATTERN_BITS-1:0] mask;

  assign shamt  = PATTERN_LENGTH_W'(MAX_PATTERN_BITS) - pattern_length;
  assign target = pattern_bits << shamt;
  assign mask   = {MAX_PATTERN_BITS{1'b1}} << shamt;

  // Cell chain: the new comparison enters the top cell, each cell hands its
  // bit down to its lower neighbor.
  logic [MAX_PATTERN_BITS-1:0] hist;
  logic [MAX_PATTERN_BITS-1:0] miss;

  for (genvar k = 0; k < MAX_PATTERN_BITS; k++) begin : g_cell
    logic shift_in;
    if (k == MAX_PATTERN_BITS - 1) begin : g_top
      assign shift_in = cmp_bit;
    end else begin : g_rest
      assign shift_in = hist[k+1];
    end
    cpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .shift_in (shift_in),
      .tgt_bit  (target[k]),
      .mask_bit (mask[k]),
      .hist     (hist[k]),
      .miss     (miss[k])
    );
  end

  // Match decision and counters.
  logic                        length_ok;
  logic                        enough;
  logic                        found;
  logic [COUNT_W-1:0]          start;
  logic [COUNT_W-1:0]          total_next;
  logic [COUNT_W-1:0]          seen_next;

  assign length_ok = (pattern_length >= PATTERN_LENGTH_W'(MIN_PATTERN_BITS)) &&
                     (pattern_length <= PATTERN_LENGTH_W'(MAX_PATTERN_BITS));
  // The window needs pattern_length comparisons inside this text.
  assign enough    = (samples_seen >= COUNT_W'(pattern_length));
  assign found     = has_prev && length_ok && enough && (miss == '0);
  assign start     = found ? (samples_seen - COUNT_W'(pattern_length)) : '0;
  assign total_next = (found && (matches_counted != COUNT_MAX)) ?
                      matches_counted + COUNT_W'(1) : matches_counted;
  assign seen_next  = (samples_seen != COUNT_MAX) ?
                      samples_seen + COUNT_W'(1) : samples_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value  <= '0;
      samples_seen    <= '0;
      matches_counted <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        // End of text: drop all per-text state.
        previous_value  <= '0;
        samples_seen    <= '0;
        matches_counted <= '0;
      end else begin
        previous_value  <= s_tdata;
        samples_seen    <= seen_next;
        matches_counted <= total_next;
      end
    end
  end

  // Result transaction and output buffering.
  result_t res;
  result_t out_res;

  assign res.match_found = found;
  assign res.match_start = start;
  assign res.match_total = total_next;

  cpm_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (res),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_data   (out_res),
    .out_ready  (m_tready)
  );

  assign m_tdata = {out_res.match_total, out_res.match_start};
  assign m_tuser = out_res.match_found;

endmodule
